### src/hsv_to_rgb_converter_assert.svh
// ---------------------------------------------------------------------------
// hsv to rgb converter assertion macros
// shared property forms for the port checker of the converter
// ---------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// expression must hold at every edge outside reset
`define HSV_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("hsv_to_rgb_converter: invariant violated");

// antecedent implies consequent sequence outside reset
`define HSV_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("hsv_to_rgb_converter: implication violated");

`endif

### src/hsv2rgb_pkg.sv
// ---------------------------------------------------------------------------
// hsv to rgb package
// widths, constants and stage records of the hsv to rgb converter
// ---------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

   // port field widths
   localparam int HUE_W  = 16;
   localparam int PCT_W  = 12;
   localparam int CHAN_W = 8;

   // clamped value widths
   localparam int HUE_CL_W = 15;             // 0..23040
   localparam int PCT_CL_W = 10;             // 0..1000
   localparam int REM_W    = 12;             // 0..3839, weight up to 3840
   localparam int SEC_W    = 3;

   localparam int HUE_MAX    = 23040;
   localparam int PCT_MAX    = 1000;
   localparam int SECTOR_LEN = 3840;
   localparam int NUM_SECT   = 6;

   // channel term: floor((17*v*x + 128e6) / 256e6), x = 3840000 - s*k
   localparam int X_W        = 22;
   localparam int UNIT_SQ    = 3840000;
   localparam int V17_W      = 15;           // 17*1000 = 17000
   localparam int PROD_W     = 36;           // below 2^36
   localparam int ROUND_BIAS = 128000000;
   localparam int SCALE_SH   = 11;           // 256e6 = 2^11 * 125000
   localparam int M_W        = 25;           // below 2^25 after the shift

   // divide by 125000 as multiply by ceil(2^45 / 125000), exact for m < 2^25
   localparam int RECIP_W  = 29;
   localparam int RECIP_SH = 45;
   localparam logic [RECIP_W-1:0] RECIP = 29'd281474977;
   localparam int QP_W     = M_W + RECIP_W;

   // pipeline depth from accepted word to result strobe
   localparam int LATENCY = 5;

   // lanes of the four candidate channel values
   localparam int NUM_LANE = 4;
   localparam int LANE_V   = 0;
   localparam int LANE_P   = 1;
   localparam int LANE_Q   = 2;
   localparam int LANE_T   = 3;

   typedef enum logic [SEC_W-1:0] {
      SEC_RED_YEL  = 3'd0,
      SEC_YEL_GRN  = 3'd1,
      SEC_GRN_CYN  = 3'd2,
      SEC_CYN_BLU  = 3'd3,
      SEC_BLU_MAG  = 3'd4,
      SEC_MAG_RED  = 3'd5
   } sector_type;

   // stage 1 record: clamped inputs and hue split
   typedef struct packed {
      logic [PCT_CL_W-1:0] sat;
      logic [PCT_CL_W-1:0] val;
      sector_type          sector;
      logic [REM_W-1:0]    rem;
   } st1_type;

endpackage

`default_nettype wire

### src/hsv_to_rgb_converter.sv
// ---------------------------------------------------------------------------
// hsv to rgb converter
// fixed point hsv to 8-bit rgb conversion, fully pipelined
// ---------------------------------------------------------------------------
// A new word may be started in every clock cycle; busy is always low. Each
// word yields one result on rsp_red/green/blue with rsp_valid high for one
// cycle. The result passes through five register stages: clamp and hue
// split, saturation weight multiplies, value multiply, reciprocal multiply
// for the divide by 125000, and channel select. The receiver cannot stall,
// so results are delivered in order with no holding.
// ---------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [hsv2rgb_pkg::HUE_W-1:0]   req_hue,
   input  logic signed [hsv2rgb_pkg::PCT_W-1:0]   req_saturation,
   input  logic signed [hsv2rgb_pkg::PCT_W-1:0]   req_brightness,
   output logic                                   rsp_valid,
   output logic        [hsv2rgb_pkg::CHAN_W-1:0]  rsp_red,
   output logic        [hsv2rgb_pkg::CHAN_W-1:0]  rsp_green,
   output logic        [hsv2rgb_pkg::CHAN_W-1:0]  rsp_blue
);

   // valid bits per stage
   logic [hsv2rgb_pkg::LATENCY-1:0] vld_ff, vld_in;

   // stage 1
   hsv2rgb_pkg::st1_type st1_ff, st1_in;
   logic [hsv2rgb_pkg::HUE_CL_W-1:0] hue_cl;

   // stage 2
   logic [hsv2rgb_pkg::X_W-1:0]      x_ff  [hsv2rgb_pkg::NUM_LANE];
   logic [hsv2rgb_pkg::X_W-1:0]      x_in  [hsv2rgb_pkg::NUM_LANE];
   logic [hsv2rgb_pkg::V17_W-1:0]    v17_ff, v17_in;
   hsv2rgb_pkg::sector_type          sec2_ff;

   // stage 3
   logic [hsv2rgb_pkg::M_W-1:0]      m_ff  [hsv2rgb_pkg::NUM_LANE];
   logic [hsv2rgb_pkg::M_W-1:0]      m_in  [hsv2rgb_pkg::NUM_LANE];
   hsv2rgb_pkg::sector_type          sec3_ff;

   // stage 4
   logic [hsv2rgb_pkg::CHAN_W-1:0]   c_ff  [hsv2rgb_pkg::NUM_LANE];
   logic [hsv2rgb_pkg::CHAN_W-1:0]   c_in  [hsv2rgb_pkg::NUM_LANE];
   hsv2rgb_pkg::sector_type          sec4_ff;

   // stage 5
   logic [hsv2rgb_pkg::CHAN_W-1:0]   red_ff, red_in;
   logic [hsv2rgb_pkg::CHAN_W-1:0]   grn_ff, grn_in;
   logic [hsv2rgb_pkg::CHAN_W-1:0]   blu_ff, blu_in;

   // clamp a signed percentage to 0..1000
   function automatic logic [hsv2rgb_pkg::PCT_CL_W-1:0] clamp_pct(
      input logic signed [hsv2rgb_pkg::PCT_W-1:0] raw
   );
      logic [hsv2rgb_pkg::PCT_CL_W-1:0] res;
      if (raw < 0) begin
         res = '0;
      end else if (raw > hsv2rgb_pkg::PCT_W'(hsv2rgb_pkg::PCT_MAX)) begin
         res = hsv2rgb_pkg::PCT_CL_W'(hsv2rgb_pkg::PCT_MAX);
      end else begin
         res = raw[hsv2rgb_pkg::PCT_CL_W-1:0];
      end
      return res;
   endfunction

   // never stalls
   assign busy = 1'b0;

   // valid pipeline
   always_comb begin
      vld_in = {vld_ff[hsv2rgb_pkg::LATENCY-2:0], start & ~busy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: clamp and split hue into sector and remainder
   always_comb begin
      logic [hsv2rgb_pkg::HUE_CL_W-1:0] base;
      logic [hsv2rgb_pkg::HUE_CL_W-1:0] diff;
      if (req_hue < 0) begin
         hue_cl = '0;
      end else if (req_hue > hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::HUE_MAX)) begin
         hue_cl = hsv2rgb_pkg::HUE_CL_W'(hsv2rgb_pkg::HUE_MAX);
      end else begin
         hue_cl = req_hue[hsv2rgb_pkg::HUE_CL_W-1:0];
      end
      st1_in.sat    = clamp_pct(req_saturation);
      st1_in.val    = clamp_pct(req_brightness);
      st1_in.sector = hsv2rgb_pkg::SEC_RED_YEL;
      base          = '0;
      for (int k = 1; k < hsv2rgb_pkg::NUM_SECT; k++) begin
         if (hue_cl >= hsv2rgb_pkg::HUE_CL_W'(k * hsv2rgb_pkg::SECTOR_LEN)) begin
            st1_in.sector = hsv2rgb_pkg::sector_type'(hsv2rgb_pkg::SEC_W'(k));
            base          = hsv2rgb_pkg::HUE_CL_W'(k * hsv2rgb_pkg::SECTOR_LEN);
         end
      end
      diff = hue_cl - base;
      // full circle folds into the last sector with zero fraction
      if (hue_cl >= hsv2rgb_pkg::HUE_CL_W'(hsv2rgb_pkg::HUE_MAX)) begin
         st1_in.rem = '0;
      end else begin
         st1_in.rem = diff[hsv2rgb_pkg::REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      st1_ff <= st1_in;
   end

   // stage 2: x = 3840000 - s*k for each lane, and 17*v
   always_comb begin
      logic [hsv2rgb_pkg::REM_W-1:0] wgt [hsv2rgb_pkg::NUM_LANE];
      wgt[hsv2rgb_pkg::LANE_V] = '0;
      wgt[hsv2rgb_pkg::LANE_P] = hsv2rgb_pkg::REM_W'(hsv2rgb_pkg::SECTOR_LEN);
      wgt[hsv2rgb_pkg::LANE_Q] = st1_ff.rem;
      wgt[hsv2rgb_pkg::LANE_T] = hsv2rgb_pkg::REM_W'(hsv2rgb_pkg::SECTOR_LEN) - st1_ff.rem;
      for (int c = 0; c < hsv2rgb_pkg::NUM_LANE; c++) begin
         x_in[c] = hsv2rgb_pkg::X_W'(hsv2rgb_pkg::UNIT_SQ)
                 - (hsv2rgb_pkg::X_W'(st1_ff.sat) * hsv2rgb_pkg::X_W'(wgt[c]));
      end
      v17_in = (hsv2rgb_pkg::V17_W'(st1_ff.val) << 4) + hsv2rgb_pkg::V17_W'(st1_ff.val);
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      v17_ff  <= v17_in;
      sec2_ff <= st1_ff.sector;
   end

   // stage 3: 17*v*x plus half, scaled down by 2^11
   always_comb begin
      logic [hsv2rgb_pkg::PROD_W-1:0] num;
      for (int c = 0; c < hsv2rgb_pkg::NUM_LANE; c++) begin
         num = hsv2rgb_pkg::PROD_W'(v17_ff) * hsv2rgb_pkg::PROD_W'(x_ff[c])
             + hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::ROUND_BIAS);
         m_in[c] = num[hsv2rgb_pkg::SCALE_SH +: hsv2rgb_pkg::M_W];
      end
   end

   always_ff @(posedge clock) begin
      m_ff    <= m_in;
      sec3_ff <= sec2_ff;
   end

   // stage 4: divide by 125000 through the reciprocal
   always_comb begin
      logic [hsv2rgb_pkg::QP_W-1:0] qp;
      for (int c = 0; c < hsv2rgb_pkg::NUM_LANE; c++) begin
         qp = hsv2rgb_pkg::QP_W'(m_ff[c]) * hsv2rgb_pkg::QP_W'(hsv2rgb_pkg::RECIP);
         c_in[c] = qp[hsv2rgb_pkg::RECIP_SH +: hsv2rgb_pkg::CHAN_W];
      end
   end

   always_ff @(posedge clock) begin
      c_ff    <= c_in;
      sec4_ff <= sec3_ff;
   end

   // stage 5: route v, p, q, t onto red, green, blue by sector
   always_comb begin
      case (sec4_ff)
         hsv2rgb_pkg::SEC_RED_YEL: begin
            red_in = c_ff[hsv2rgb_pkg::LANE_V];
            grn_in = c_ff[hsv2rgb_pkg::LANE_T];
            blu_in = c_ff[hsv2rgb_pkg::LANE_P];
         end
         hsv2rgb_pkg::SEC_YEL_GRN: begin
            red_in = c_ff[hsv2rgb_pkg::LANE_Q];
            grn_in = c_ff[hsv2rgb_pkg::LANE_V];
            blu_in = c_ff[hsv2rgb_pkg::LANE_P];
         end
         hsv2rgb_pkg::SEC_GRN_CYN: begin
            red_in = c_ff[hsv2rgb_pkg::LANE_P];
            grn_in = c_ff[hsv2rgb_pkg::LANE_V];
            blu_in = c_ff[hsv2rgb_pkg::LANE_T];
         end
         hsv2rgb_pkg::SEC_CYN_BLU: begin
            red_in = c_ff[hsv2rgb_pkg::LANE_P];
            grn_in = c_ff[hsv2rgb_pkg::LANE_Q];
            blu_in = c_ff[hsv2rgb_pkg::LANE_V];
         end
         hsv2rgb_pkg::SEC_BLU_MAG: begin
            red_in = c_ff[hsv2rgb_pkg::LANE_T];
            grn_in = c_ff[hsv2rgb_pkg::LANE_P];
            blu_in = c_ff[hsv2rgb_pkg::LANE_V];
         end
         default: begin
            red_in = c_ff[hsv2rgb_pkg::LANE_V];
            grn_in = c_ff[hsv2rgb_pkg::LANE_P];
            blu_in = c_ff[hsv2rgb_pkg::LANE_Q];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      red_ff <= red_in;
      grn_ff <= grn_in;
      blu_ff <= blu_in;
   end

   assign rsp_valid = vld_ff[hsv2rgb_pkg::LATENCY-1];
   assign rsp_red   = red_ff;
   assign rsp_green = grn_ff;
   assign rsp_blue  = blu_ff;

endmodule

`default_nettype wire

### src/hsv2rgb_checker.sv
// ---------------------------------------------------------------------------
// hsv to rgb port checker
// timing and value checks on the converter ports, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "hsv_to_rgb_converter_assert.svh"

module hsv2rgb_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic signed [hsv2rgb_pkg::PCT_W-1:0]   req_saturation,
   input  logic signed [hsv2rgb_pkg::PCT_W-1:0]   req_brightness,
   input  logic                                   rsp_valid,
   input  logic        [hsv2rgb_pkg::CHAN_W-1:0]  rsp_red,
   input  logic        [hsv2rgb_pkg::CHAN_W-1:0]  rsp_green,
   input  logic        [hsv2rgb_pkg::CHAN_W-1:0]  rsp_blue
);

   logic word_acc;
   logic grey_word;
   logic black_word;
   logic rsp_grey;
   logic rsp_black;

   // accepted words and result shapes
   assign word_acc   = start && !busy;
   assign grey_word  = word_acc && (req_saturation <= 0);
   assign black_word = word_acc && (req_brightness <= 0);
   assign rsp_grey   = (rsp_red == rsp_green) && (rsp_green == rsp_blue);
   assign rsp_black  = (rsp_red == '0) && (rsp_green == '0) && (rsp_blue == '0);

   // converter takes a word every cycle
   `HSV_ASSERT_ALWAYS(a_never_busy, clock, reset, !busy)

   // every accepted word gives a result after the pipeline depth
   `HSV_ASSERT_IMPLY(a_word_gives_result, clock, reset, word_acc, ##(hsv2rgb_pkg::LATENCY) rsp_valid)

   // no result without a word accepted the pipeline depth earlier
   `HSV_ASSERT_IMPLY(a_no_spurious_result, clock, reset, rsp_valid, $past(start, hsv2rgb_pkg::LATENCY))

   // zero saturation gives grey
   `HSV_ASSERT_IMPLY(a_grey, clock, reset, grey_word, ##(hsv2rgb_pkg::LATENCY) rsp_grey)

   // zero value gives black
   `HSV_ASSERT_IMPLY(a_black, clock, reset, black_word, ##(hsv2rgb_pkg::LATENCY) rsp_black)

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_saturation (req_saturation),
   .req_brightness (req_brightness),
   .rsp_valid      (rsp_valid),
   .rsp_red        (rsp_red),
   .rsp_green      (rsp_green),
   .rsp_blue       (rsp_blue)
);

`default_nettype wire
